// ----- hw/rtl/usdcd_pkg.sv -----
// Shared constants, item type and byte transpose for the unshuffle delta decoder.
package usdcd_pkg;

    localparam int WORD_W        = 32;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 24;
    localparam int SCALE_W       = 17;
    localparam int COORD_W       = 56;
    localparam int SUM_WIDTH_DEF = 40;
    localparam int GROUP_N       = 4;
    localparam int FIFO_DEPTH    = 8;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [ADDR_W-1:0]  ADDR_WORD_COUNT = 3'd0;
    localparam logic [ADDR_W-1:0]  ADDR_RECIP_SCALE = 3'd4;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [IDX_W-1:0]  idx;
        logic              last_run;
        logic              accum;
        logic              last_arr;
    } item_t;

    function automatic logic [WORD_W-1:0] unshuffle(
        input logic [WORD_W-1:0] w0,
        input logic [WORD_W-1:0] w1,
        input logic [WORD_W-1:0] w2,
        input logic [WORD_W-1:0] w3,
        input logic [1:0]        k
    );
        logic [WORD_W-1:0] res;
        res = {w3[BYTE_W*k +: BYTE_W], w2[BYTE_W*k +: BYTE_W],
               w1[BYTE_W*k +: BYTE_W], w0[BYTE_W*k +: BYTE_W]};
        return res;
    endfunction

endpackage

// ----- hw/rtl/unshuffle_delta_coordinate_decoder.sv -----
// Byte unshuffle, delta accumulation and reciprocal scaling of an integer array.
// A result passes the queue, then the accumulate, multiply and output registers;
// a group's four results enter the queue together when its fourth word is taken.
// Throughput: one word per cycle in; one result per cycle out while out_ready holds;
// results queue in an 8-entry buffer and in_ready drops while more than four wait.
// Reset clears the stream position, both running sums, the queue and the pipeline;
// word_count resets to 0 and reciprocal_scale to 1.0.
module unshuffle_delta_coordinate_decoder #(
    parameter int SUM_WIDTH = usdcd_pkg::SUM_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [usdcd_pkg::ADDR_W-1:0]         paddr,
    input  logic [usdcd_pkg::DATA_W-1:0]         pwdata,
    output logic [usdcd_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [usdcd_pkg::WORD_W-1:0]         stored_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [usdcd_pkg::COORD_W-1:0] coordinate,
    output logic                                 is_y_axis,
    output logic [usdcd_pkg::IDX_W-1:0]          element_index,
    output logic                                 saturated,
    output logic                                 last_in_run,
    output logic                                 last_of_array
);

    localparam int WORD_W  = usdcd_pkg::WORD_W;
    localparam int IDX_W   = usdcd_pkg::IDX_W;
    localparam int SCALE_W = usdcd_pkg::SCALE_W;
    localparam int COORD_W = usdcd_pkg::COORD_W;
    localparam int GROUP_N = usdcd_pkg::GROUP_N;
    localparam int DEPTH   = usdcd_pkg::FIFO_DEPTH;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PROD_W  = SUM_WIDTH + SCALE_W + 1;
    localparam int EXT_W   = (PROD_W > COORD_W) ? PROD_W : COORD_W + 1;
    localparam int UP_W    = EXT_W - COORD_W + 1;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_W-1:0]   COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0]   COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // configuration
    logic [IDX_W-1:0]   word_count_reg;
    logic [SCALE_W-1:0] reciprocal_scale_reg;
    logic               cfg_wr;

    // input side
    logic [IDX_W-1:0]  words_seen_reg, words_seen_next;
    logic [WORD_W-1:0] group_words_reg [3];
    logic [IDX_W-1:0]  cur_idx, base_idx;
    logic [IDX_W:0]    idx_inc;
    logic              take, in_grouped, group_done;
    logic [2:0]        push_n;
    usdcd_pkg::item_t  items [GROUP_N];

    // queue
    usdcd_pkg::item_t  fifo_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    usdcd_pkg::item_t  head;
    logic              pop;

    // accumulate stage
    logic signed [SUM_WIDTH-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic signed [SUM_WIDTH-1:0] head_val_ext, sum_base, sum_sat;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic                        head_first, sum_ovf;
    logic                        a_valid_reg, a_ready;
    logic signed [SUM_WIDTH-1:0] a_operand_reg;
    logic [IDX_W-1:0]            a_idx_reg;
    logic                        a_sat_reg, a_last_run_reg, a_last_arr_reg;

    // multiply stage
    logic                        b_valid_reg, b_ready;
    logic signed [PROD_W-1:0]    b_prod_reg;
    logic [IDX_W-1:0]            b_idx_reg;
    logic                        b_sat_reg, b_last_run_reg, b_last_arr_reg;

    // result stage
    logic                        c_ready;
    logic signed [EXT_W-1:0]     prod_ext;
    logic [UP_W-1:0]             prod_upper;
    logic signed [COORD_W-1:0]   coord_clamped;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg       <= '0;
            reciprocal_scale_reg <= usdcd_pkg::SCALE_ONE;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                usdcd_pkg::ADDR_WORD_COUNT:  word_count_reg <= pwdata[IDX_W-1:0];
                usdcd_pkg::ADDR_RECIP_SCALE: reciprocal_scale_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            usdcd_pkg::ADDR_WORD_COUNT:
                prdata = {{(usdcd_pkg::DATA_W-IDX_W){1'b0}}, word_count_reg};
            usdcd_pkg::ADDR_RECIP_SCALE:
                prdata = {{(usdcd_pkg::DATA_W-SCALE_W){1'b0}}, reciprocal_scale_reg};
            default:
                prdata = '0;
        endcase
    end

    // grouping and queue entry
    always_comb
    begin
        cur_idx    = (words_seen_reg >= word_count_reg) ? '0 : words_seen_reg;
        idx_inc    = {1'b0, cur_idx} + (IDX_W+1)'(1);
        in_grouped = cur_idx < {word_count_reg[IDX_W-1:2], 2'b00};
        group_done = in_grouped && (cur_idx[1:0] == 2'd3);
        take       = in_valid && in_ready && (word_count_reg != '0);
        base_idx   = group_done ? {cur_idx[IDX_W-1:2], 2'b00} : cur_idx;

        if (!take)
            push_n = 3'd0;
        else if (!in_grouped)
            push_n = 3'd1;
        else if (group_done)
            push_n = 3'(GROUP_N);
        else
            push_n = 3'd0;

        if (take)
            words_seen_next = (idx_inc >= {1'b0, word_count_reg}) ? '0 : idx_inc[IDX_W-1:0];
        else
            words_seen_next = words_seen_reg;

        for (int k = 0; k < GROUP_N; k++)
        begin
            items[k].value    = group_done
                              ? usdcd_pkg::unshuffle(group_words_reg[0], group_words_reg[1],
                                                     group_words_reg[2], stored_word, 2'(k))
                              : stored_word;
            items[k].idx      = base_idx + IDX_W'(k);
            items[k].last_run = group_done ? (k == GROUP_N - 1) : 1'b1;
            items[k].accum    = items[k].idx < {word_count_reg[IDX_W-1:1], 1'b0};
            items[k].last_arr = ({1'b0, items[k].idx} + (IDX_W+1)'(1))
                             == {1'b0, word_count_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_grouped && !group_done)
            group_words_reg[cur_idx[1:0]] <= stored_word;
        for (int k = 0; k < GROUP_N; k++)
        begin
            if (3'(k) < push_n)
                fifo_reg[wr_ptr_reg + PTR_W'(k)] <= items[k];
        end
    end

    assign in_ready   = count_reg <= CNT_W'(DEPTH - GROUP_N);
    assign head       = fifo_reg[rd_ptr_reg];
    assign pop        = (count_reg != '0) && a_ready;
    assign count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    // running sums
    always_comb
    begin
        head_first   = head.idx == '0;
        head_val_ext = SUM_WIDTH'($signed(head.value));
        sum_base     = head_first ? '0 : (head.idx[0] ? sum_y_reg : sum_x_reg);
        sum_wide     = {sum_base[SUM_WIDTH-1], sum_base}
                     + {head_val_ext[SUM_WIDTH-1], head_val_ext};
        sum_ovf      = sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1];
        if (!sum_ovf)
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        else if (sum_wide[SUM_WIDTH])
            sum_sat = SUM_MIN;
        else
            sum_sat = SUM_MAX;

        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        if (pop)
        begin
            if (head_first)
            begin
                sum_x_next = '0;
                sum_y_next = '0;
            end
            if (head.accum)
            begin
                if (head.idx[0])
                    sum_y_next = sum_sat;
                else
                    sum_x_next = sum_sat;
            end
        end
    end

    // product clamp
    always_comb
    begin
        prod_ext   = EXT_W'(b_prod_reg);
        prod_upper = prod_ext[EXT_W-1:COORD_W-1];
        if ((&prod_upper) || !(|prod_upper))
            coord_clamped = prod_ext[COORD_W-1:0];
        else if (prod_upper[UP_W-1])
            coord_clamped = COORD_MIN;
        else
            coord_clamped = COORD_MAX;
    end

    assign c_ready = !out_valid || out_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_seen_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_valid      <= 1'b0;
        end
        else
        begin
            words_seen_reg <= words_seen_next;
            wr_ptr_reg     <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg     <= rd_ptr_reg + PTR_W'(pop);
            count_reg      <= count_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            if (a_ready)
                a_valid_reg <= count_reg != '0;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                out_valid <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_operand_reg  <= head.accum ? sum_sat : head_val_ext;
            a_idx_reg      <= head.idx;
            a_sat_reg      <= head.accum && sum_ovf;
            a_last_run_reg <= head.last_run;
            a_last_arr_reg <= head.last_arr;
        end
        if (b_ready && a_valid_reg)
        begin
            b_prod_reg     <= PROD_W'(a_operand_reg * $signed({1'b0, reciprocal_scale_reg}));
            b_idx_reg      <= a_idx_reg;
            b_sat_reg      <= a_sat_reg;
            b_last_run_reg <= a_last_run_reg;
            b_last_arr_reg <= a_last_arr_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            coordinate    <= coord_clamped;
            is_y_axis     <= b_idx_reg[0];
            element_index <= b_idx_reg;
            saturated     <= b_sat_reg;
            last_in_run   <= b_last_run_reg;
            last_of_array <= b_last_arr_reg;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue over capacity");

    a_push_size: assert property (@(posedge clk) disable iff (!rst_n)
        push_n == 3'd0 || push_n == 3'd1 || push_n == 3'(GROUP_N))
        else $error("bad number of queued results for one beat");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        take && !cfg_wr |=> words_seen_reg < word_count_reg)
        else $error("stream position beyond word count");

    a_first_clears_y: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_first |=> sum_y_reg == '0)
        else $error("y sum not cleared at array start");

endmodule

// ----- verif/unshuffle_delta_coordinate_decoder_tb.sv -----
// Self-checking testbench for the unshuffle delta coordinate decoder with a predicting scoreboard.
module unshuffle_delta_coordinate_decoder_tb;

    localparam int WORD_W        = usdcd_pkg::WORD_W;
    localparam int BYTE_W        = usdcd_pkg::BYTE_W;
    localparam int IDX_W         = usdcd_pkg::IDX_W;
    localparam int SCALE_W       = usdcd_pkg::SCALE_W;
    localparam int COORD_W       = usdcd_pkg::COORD_W;
    localparam int GROUP_N       = usdcd_pkg::GROUP_N;
    localparam int ADDR_W        = usdcd_pkg::ADDR_W;
    localparam int DATA_W        = usdcd_pkg::DATA_W;
    localparam int SUM_W         = usdcd_pkg::SUM_WIDTH_DEF;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 120;

    localparam logic [SCALE_W-1:0] SCALE_ONE        = usdcd_pkg::SCALE_ONE;
    localparam logic [ADDR_W-1:0]  ADDR_WORD_COUNT  = usdcd_pkg::ADDR_WORD_COUNT;
    localparam logic [ADDR_W-1:0]  ADDR_RECIP_SCALE = usdcd_pkg::ADDR_RECIP_SCALE;

    typedef struct packed {
        logic signed [COORD_W-1:0] coordinate;
        logic                      is_y_axis;
        logic [IDX_W-1:0]          element_index;
        logic                      saturated;
        logic                      last_in_run;
        logic                      last_of_array;
    } coord_beat_t;

    class coord_checker;
        logic [IDX_W-1:0]        word_count;
        logic [SCALE_W-1:0]      recip_scale;
        logic [WORD_W-1:0]       group_words [3];
        logic [2:0]              slot_written;
        logic [IDX_W-1:0]        words_seen;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        coord_beat_t             awaited [$];
        int unsigned             mismatches;

        function new();
            word_count  = '0;
            recip_scale = SCALE_ONE;
            mismatches  = 0;
            foreach (group_words[i])
                group_words[i] = '0;
            restart();
        endfunction

        function void restart();
            words_seen   = '0;
            sum_x        = '0;
            sum_y        = '0;
            slot_written = '0;
        endfunction

        function void predict_integer(logic [WORD_W-1:0] value, logic [IDX_W-1:0] idx,
                                      logic last_run);
            coord_beat_t beat;
            longint      total;
            longint      product;
            longint      sum_hi;
            longint      coord_hi;
            sum_hi   = (longint'(1) <<< (SUM_W - 1)) - 1;
            coord_hi = (longint'(1) <<< (COORD_W - 1)) - 1;
            total    = longint'($signed(value));
            beat.saturated = 1'b0;
            if (idx < (word_count & ~24'd1))
            begin
                total = total + (idx[0] ? longint'(sum_y) : longint'(sum_x));
                if (total > sum_hi)
                begin
                    total = sum_hi;
                    beat.saturated = 1'b1;
                end
                else if (total < -sum_hi - 1)
                begin
                    total = -sum_hi - 1;
                    beat.saturated = 1'b1;
                end
                if (idx[0])
                    sum_y = total[SUM_W-1:0];
                else
                    sum_x = total[SUM_W-1:0];
            end
            product = total * longint'(recip_scale);
            if (product > coord_hi)
                product = coord_hi;
            else if (product < -coord_hi - 1)
                product = -coord_hi - 1;
            beat.coordinate    = product[COORD_W-1:0];
            beat.is_y_axis     = idx[0];
            beat.element_index = idx;
            beat.last_in_run   = last_run;
            beat.last_of_array = ({1'b0, idx} + 25'd1 == {1'b0, word_count});
            awaited.push_back(beat);
        endfunction

        function void take_word(logic [WORD_W-1:0] word);
            logic [IDX_W-1:0]  idx;
            logic [1:0]        slot;
            logic [WORD_W-1:0] merged;
            int                k;
            if (word_count == '0)
                return;
            if (words_seen >= word_count)
                restart();
            idx  = words_seen;
            slot = idx[1:0];
            if (slot == 2'd0)
                slot_written = '0;
            if (idx < (word_count & ~24'd3))
            begin
                if (slot != 2'd3)
                begin
                    group_words[slot]  = word;
                    slot_written[slot] = 1'b1;
                end
                else
                begin
                    for (k = 0; k < GROUP_N; k++)
                    begin
                        merged = {word[BYTE_W*k +: BYTE_W],
                                  group_words[2][BYTE_W*k +: BYTE_W],
                                  group_words[1][BYTE_W*k +: BYTE_W],
                                  group_words[0][BYTE_W*k +: BYTE_W]};
                        predict_integer(merged, idx - IDX_W'(3 - k), k == 3);
                    end
                end
            end
            else
                predict_integer(word, idx, 1'b1);
            words_seen = idx + 1'b1;
            if ({1'b0, idx} + 25'd1 >= {1'b0, word_count})
                restart();
        endfunction

        // a new count must never make the block read a group slot left unwritten
        function bit count_change_safe(logic [IDX_W-1:0] new_count);
            logic [2:0] needed;
            if (new_count == '0 || words_seen >= new_count)
                return 1'b1;
            if (words_seen >= (new_count & ~24'd3))
                return 1'b1;
            needed = (3'b001 << words_seen[1:0]) - 3'b001;
            return (slot_written & needed) == needed;
        endfunction

        function void match_coordinate(coord_beat_t got);
            coord_beat_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d coordinate %0d",
                             got.element_index, $signed(got.coordinate));
                return;
            end
            want = awaited.pop_front();
            if (want.coordinate !== got.coordinate || want.is_y_axis !== got.is_y_axis ||
                want.element_index !== got.element_index ||
                want.saturated !== got.saturated || want.last_in_run !== got.last_in_run ||
                want.last_of_array !== got.last_of_array)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected coord %0d y %0b idx %0d sat %0b run %0b arr %0b",
                             $signed(want.coordinate), want.is_y_axis, want.element_index,
                             want.saturated, want.last_in_run, want.last_of_array);
                    $display("          got coord %0d y %0b idx %0d sat %0b run %0b arr %0b",
                             $signed(got.coordinate), got.is_y_axis, got.element_index,
                             got.saturated, got.last_in_run, got.last_of_array);
                end
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic [WORD_W-1:0]         stored_word;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] coordinate;
    logic                      is_y_axis;
    logic [IDX_W-1:0]          element_index;
    logic                      saturated;
    logic                      last_in_run;
    logic                      last_of_array;

    coord_checker coords;
    bit           steady;
    int           stall_left = 0;
    int           cycle_count;

    unshuffle_delta_coordinate_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stored_word   (stored_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .coordinate    (coordinate),
        .is_y_axis     (is_y_axis),
        .element_index (element_index),
        .saturated     (saturated),
        .last_in_run   (last_in_run),
        .last_of_array (last_of_array)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 512) - 32'd256;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            2: return {4{8'($urandom_range(0, 255))}};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] random_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return IDX_W'($urandom_range(1, 8));
            4, 5, 6: return IDX_W'($urandom_range(9, 40));
            7: return IDX_W'($urandom_range(41, 200));
            default: return IDX_W'($urandom());
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] random_scale();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return SCALE_ONE;
            2: return '1;
            3: return SCALE_W'($urandom_range(0, 17'h1FFFF));
            default: return SCALE_W'($urandom_range(0, SCALE_ONE));
        endcase
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        stored_word <= word;
        do
            @(posedge clk);
        while (!in_ready);
        coords.take_word(word);
    endtask

    task automatic stop_words();
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        while (coords.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WORD_COUNT)
            coords.word_count = data[IDX_W-1:0];
        else if (addr == ADDR_RECIP_SCALE)
            coords.recip_scale = data[SCALE_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input logic [IDX_W-1:0] count, input logic [SCALE_W-1:0] scale);
        write_reg(ADDR_WORD_COUNT, DATA_W'(count));
        write_reg(ADDR_RECIP_SCALE, DATA_W'(scale));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                coords.match_coordinate(coord_beat_t'{coordinate, is_y_axis, element_index,
                                                      saturated, last_in_run, last_of_array});
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** unshuffle_delta_coordinate_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        logic [WORD_W-1:0] opening [7];
        logic [IDX_W-1:0]  count;
        int                sent;
        int                burst;
        int                i;
        opening     = '{32'h3322_1100, 32'h7766_5544, 32'hBBAA_9988, 32'hFFEE_DDCC,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        stored_word = '0;
        steady      = 1'b0;
        coords      = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero count: words are dropped
        send_word(32'h1234_5678);
        send_word(32'hFFFF_FFFF);
        stop_words();
        settle();

        // one transposed group, two accumulated pass-through words, odd final word
        configure(24'd7, 17'h08000);
        foreach (opening[j])
            send_word(opening[j]);
        stop_words();
        settle();

        // lower the count mid-array, then raise it on a group boundary
        configure(24'd20, SCALE_ONE);
        for (i = 0; i < 6; i++)
            send_word(random_word());
        stop_words();
        settle();
        write_reg(ADDR_WORD_COUNT, DATA_W'(24'd5));
        for (i = 0; i < 4; i++)
            send_word(random_word());
        stop_words();
        settle();
        write_reg(ADDR_WORD_COUNT, DATA_W'({IDX_W{1'b1}}));
        for (i = 0; i < 4; i++)
            send_word(random_word());
        stop_words();
        settle();
        configure(24'd3, '0);
        for (i = 0; i < 3; i++)
            send_word(random_word());
        stop_words();
        settle();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            count = random_count();
            if (coords.count_change_safe(count))
                write_reg(ADDR_WORD_COUNT, DATA_W'(count));
            write_reg(ADDR_RECIP_SCALE, DATA_W'(random_scale()));
            steady = ($urandom_range(0, 3) == 0);
            burst  = $urandom_range(10, 40);
            for (i = 0; i < burst; i++)
            begin
                if (i == burst / 2 && $urandom_range(0, 3) == 0)
                begin
                    stop_words();
                    settle();
                end
                send_word(random_word());
            end
            sent += burst;
            stop_words();
            settle();
        end
        steady = 1'b0;

        if (coords.mismatches == 0 && coords.awaited.size() == 0)
            $display("** unshuffle_delta_coordinate_decoder: PASSED **");
        else
            $display("** unshuffle_delta_coordinate_decoder: FAILED **");
        $finish;
    end

endmodule
